### rtl/gld_pkg.sv
// shared types, constants and date helpers for the gregorian to lunar date unit
package gld_pkg;

   localparam int FIRST_YEAR_DEF = 1901;
   localparam int YEAR_COUNT_DEF = 256;
   localparam int TERMS_PER_YEAR = 24;
   localparam int TERM_ROWS      = 12;
   localparam int MONTH_STEPS    = 13;
   localparam logic [4:0] NO_TERM = 5'd24;

   // reciprocal of 100, exact for 12-bit operands
   localparam int RECIP_100   = 1311;
   localparam int RECIP_SHIFT = 17;

   typedef enum logic [1:0] {
      OP_CONVERT     = 2'd0,
      OP_WR_NEW_YEAR = 2'd1,
      OP_WR_MONTHS   = 2'd2,
      OP_WR_TERM     = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [7:0]  table_index;
      logic [4:0]  term_index;
      logic [20:0] table_value;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] lunar_year;
      logic [3:0]  moon_month;
      logic [4:0]  lunar_day;
      logic        leap_flag;
      logic [4:0]  term_no;
   } rsp_type;

   // days in the year before the first of a month, zero for bad months
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // floor(v / 100) by reciprocal multiply
   function automatic logic [5:0] div100(input logic [11:0] v);
      logic [23:0] prod;
      prod = 24'(v) * 24'(RECIP_100);
      return 6'(prod >> RECIP_SHIFT);
   endfunction

   // gregorian leap year from the year and its quotient by 100
   function automatic logic is_leap(input logic [11:0] y, input logic [5:0] q);
      logic cent;
      cent = (y == 12'(13'(q) * 13'd100));
      return ((y[1:0] == 2'd0) && !cent) || (cent && (q[1:0] == 2'd0));
   endfunction

endpackage

### rtl/gregorian_to_lunar_date_unit.sv
// gregorian to chinese lunar date converter with loadable year tables
// stages: table read, slot choice, quotients, year base, day numbers, month walk, output
// one item per cycle unless stalled; the 13 month-length steps are 13 pipeline stages
// table loads give no result; a held result with rsp_stall freezes the whole pipeline
// reset clears the valid bits only; table contents are undefined until loaded
module gregorian_to_lunar_date_unit #(
   parameter int FIRST_YEAR = gld_pkg::FIRST_YEAR_DEF,
   parameter int YEAR_COUNT = gld_pkg::YEAR_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gld_pkg::rsp_type rsp_data
);
   import gld_pkg::*;

   localparam int IDX_W      = (YEAR_COUNT > 1) ? $clog2(YEAR_COUNT) : 1;
   localparam int TERM_DEPTH = YEAR_COUNT * TERM_ROWS;
   localparam int TERM_AW    = $clog2(TERM_DEPTH);
   localparam int WALK_STEPS = MONTH_STEPS;
   localparam logic [12:0] FIRST_V = 13'(FIRST_YEAR);
   localparam logic [12:0] LAST_V  = 13'(FIRST_YEAR + YEAR_COUNT - 1);
   localparam logic [8:0]  COUNT_V = 9'(YEAR_COUNT);

   typedef struct packed {
      logic        ok;
      logic [11:0] lyear;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  term_even;
      logic [4:0]  term_odd;
      logic [16:0] months;
   } ctx_type;

   // table memories; new-year and month tables are doubled for the two slot reads
   logic [20:0] ny_cur_mem   [YEAR_COUNT];
   logic [20:0] ny_prev_mem  [YEAR_COUNT];
   logic [16:0] ml_cur_mem   [YEAR_COUNT];
   logic [16:0] ml_prev_mem  [YEAR_COUNT];
   logic [4:0]  term_even_mem[TERM_DEPTH];
   logic [4:0]  term_odd_mem [TERM_DEPTH];

   logic adv;
   logic accept;

   // write decode
   logic               wr_idx_ok;
   logic               wr_term_ok;
   logic [IDX_W-1:0]   wr_idx;
   logic [TERM_AW-1:0] wr_taddr;

   // read decode
   logic [11:0]        rd_row;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   rd_prev;
   logic [TERM_AW-1:0] rd_taddr;
   logic               in_range;

   // stage 1: table reads
   logic        s1_v_ff;
   logic [11:0] s1_year_ff;
   logic [3:0]  s1_month_ff;
   logic [4:0]  s1_day_ff;
   logic        s1_inr_ff;
   logic        s1_row0_ff;
   logic [20:0] s1_ny_cur_ff, s1_ny_prev_ff;
   logic [16:0] s1_ml_cur_ff, s1_ml_prev_ff;
   logic [4:0]  s1_te_ff, s1_to_ff;

   // stage 2: slot choice
   logic        s2_later;
   logic [20:0] s2_ny_sel;
   ctx_type     s2_ctx_in;
   logic        s2_v_ff;
   ctx_type     s2_ctx_ff;
   logic [11:0] s2_y_in_ff, s2_y_ny_ff;
   logic [3:0]  s2_m_ny_ff;
   logic [4:0]  s2_d_ny_ff;

   // stage 3: quotients by 100
   logic [11:0] s3_p_in, s3_p_ny;
   logic        s3_v_ff;
   ctx_type     s3_ctx_ff;
   logic [11:0] s3_y_in_ff, s3_y_ny_ff, s3_p_in_ff, s3_p_ny_ff;
   logic [5:0]  s3_qp_in_ff, s3_qp_ny_ff, s3_qy_in_ff, s3_qy_ny_ff;
   logic [3:0]  s3_m_ny_ff;
   logic [4:0]  s3_d_ny_ff;

   // stage 4: year part of the day numbers
   logic        s4_v_ff;
   ctx_type     s4_ctx_ff;
   logic [20:0] s4_base_in_ff, s4_base_ny_ff;
   logic        s4_leap_in_ff, s4_leap_ny_ff;
   logic [3:0]  s4_m_ny_ff;
   logic [4:0]  s4_d_ny_ff;

   // stage 5: full day numbers
   logic [20:0] s5_dn_in, s5_dn_ny;
   logic        s5_v_ff;
   ctx_type     s5_ctx_ff;
   logic [20:0] s5_dn_in_ff, s5_dn_ny_ff;

   // month walk stages
   logic signed [21:0] s6_offset;
   logic               walk_v_ff   [WALK_STEPS+1];
   ctx_type            walk_ctx_ff [WALK_STEPS+1];
   logic signed [21:0] walk_off_ff [WALK_STEPS+1];
   logic [3:0]         walk_mon_ff [WALK_STEPS+1];
   logic               walk_done_ff[WALK_STEPS+1];
   logic signed [21:0] walk_len    [WALK_STEPS];

   // final stage
   ctx_type            fin_ctx;
   logic [3:0]         fin_leap;
   logic [3:0]         fin_mon;
   logic               fin_is_leap;
   logic signed [21:0] fin_off;
   logic [4:0]         fin_day;
   logic [4:0]         fin_term;
   logic [4:0]         fin_sterm;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // pipeline moves unless a finished item is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // address decode for loads and reads
   always_comb begin
      wr_idx_ok  = {1'b0, req_data.table_index} < COUNT_V;
      wr_term_ok = req_data.term_index < 5'(TERMS_PER_YEAR);
      wr_idx     = req_data.table_index[IDX_W-1:0];
      wr_taddr   = TERM_AW'(16'(req_data.table_index) * 16'd12
                   + 16'(req_data.term_index[4:1]));
      rd_row     = req_data.year - FIRST_V[11:0];
      rd_idx     = rd_row[IDX_W-1:0];
      rd_prev    = rd_idx - IDX_W'(1);
      rd_taddr   = TERM_AW'(16'(rd_row) * 16'd12 + 16'(req_data.month - 4'd1));
      in_range   = ({1'b0, req_data.year} >= FIRST_V) && ({1'b0, req_data.year} <= LAST_V)
                   && (req_data.month >= 4'd1) && (req_data.month <= 4'd12)
                   && (req_data.day != 5'd0);
   end

   // table writes at accept and reads whenever the pipeline moves, so items stay in order
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_data.op == OP_WR_NEW_YEAR && wr_idx_ok) begin
            ny_cur_mem[wr_idx]  <= req_data.table_value;
            ny_prev_mem[wr_idx] <= req_data.table_value;
         end
         if (req_data.op == OP_WR_MONTHS && wr_idx_ok) begin
            ml_cur_mem[wr_idx]  <= req_data.table_value[16:0];
            ml_prev_mem[wr_idx] <= req_data.table_value[16:0];
         end
         if (req_data.op == OP_WR_TERM && wr_idx_ok && wr_term_ok) begin
            if (req_data.term_index[0]) begin
               term_odd_mem[wr_taddr] <= req_data.table_value[4:0];
            end else begin
               term_even_mem[wr_taddr] <= req_data.table_value[4:0];
            end
         end
      end
      if (adv) begin
         s1_ny_cur_ff  <= ny_cur_mem[rd_idx];
         s1_ny_prev_ff <= ny_prev_mem[rd_prev];
         s1_ml_cur_ff  <= ml_cur_mem[rd_idx];
         s1_ml_prev_ff <= ml_prev_mem[rd_prev];
         s1_te_ff      <= term_even_mem[rd_taddr];
         s1_to_ff      <= term_odd_mem[rd_taddr];
      end
   end

   // stage 2 logic: pick this year or the one before
   always_comb begin
      s2_later            = s1_ny_cur_ff > {s1_year_ff, s1_month_ff, s1_day_ff};
      s2_ny_sel           = s2_later ? s1_ny_prev_ff : s1_ny_cur_ff;
      s2_ctx_in.ok        = s1_inr_ff && !(s2_later && s1_row0_ff);
      s2_ctx_in.lyear     = s1_year_ff - {11'd0, s2_later};
      s2_ctx_in.month     = s1_month_ff;
      s2_ctx_in.day       = s1_day_ff;
      s2_ctx_in.term_even = s1_te_ff;
      s2_ctx_in.term_odd  = s1_to_ff;
      s2_ctx_in.months    = s2_later ? s1_ml_prev_ff : s1_ml_cur_ff;
   end

   // stage 3 logic: years before the date
   always_comb begin
      s3_p_in = (s2_y_in_ff == 12'd0) ? 12'd0 : s2_y_in_ff - 12'd1;
      s3_p_ny = (s2_y_ny_ff == 12'd0) ? 12'd0 : s2_y_ny_ff - 12'd1;
   end

   // stage 5 logic: add month, day and leap day
   always_comb begin
      s5_dn_in = s4_base_in_ff + 21'(days_before(s4_ctx_ff.month)) + 21'(s4_ctx_ff.day)
                 + 21'(s4_leap_in_ff && s4_ctx_ff.month > 4'd2 && s4_ctx_ff.month <= 4'd12);
      s5_dn_ny = s4_base_ny_ff + 21'(days_before(s4_m_ny_ff)) + 21'(s4_d_ny_ff)
                 + 21'(s4_leap_ny_ff && s4_m_ny_ff > 4'd2 && s4_m_ny_ff <= 4'd12);
      s6_offset = $signed({1'b0, s5_dn_in_ff}) - $signed({1'b0, s5_dn_ny_ff}) + 22'sd1;
   end

   // month length of each walk step
   always_comb begin
      for (int j = 0; j < WALK_STEPS; j++) begin
         walk_len[j] = walk_ctx_ff[j].months[MONTH_STEPS-1-j] ? 22'sd30 : 22'sd29;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_year_ff  <= req_data.year;
         s1_month_ff <= req_data.month;
         s1_day_ff   <= req_data.day;
         s1_inr_ff   <= in_range;
         s1_row0_ff  <= (rd_row == 12'd0);

         s2_ctx_ff  <= s2_ctx_in;
         s2_y_in_ff <= s1_year_ff;
         s2_y_ny_ff <= s2_ny_sel[20:9];
         s2_m_ny_ff <= s2_ny_sel[8:5];
         s2_d_ny_ff <= s2_ny_sel[4:0];

         s3_ctx_ff   <= s2_ctx_ff;
         s3_y_in_ff  <= s2_y_in_ff;
         s3_y_ny_ff  <= s2_y_ny_ff;
         s3_p_in_ff  <= s3_p_in;
         s3_p_ny_ff  <= s3_p_ny;
         s3_qp_in_ff <= div100(s3_p_in);
         s3_qp_ny_ff <= div100(s3_p_ny);
         s3_qy_in_ff <= div100(s2_y_in_ff);
         s3_qy_ny_ff <= div100(s2_y_ny_ff);
         s3_m_ny_ff  <= s2_m_ny_ff;
         s3_d_ny_ff  <= s2_d_ny_ff;

         s4_ctx_ff     <= s3_ctx_ff;
         s4_base_in_ff <= 21'(s3_p_in_ff) * 21'd365 + 21'(s3_p_in_ff[11:2])
                          - 21'(s3_qp_in_ff) + 21'(s3_qp_in_ff[5:2]);
         s4_base_ny_ff <= 21'(s3_p_ny_ff) * 21'd365 + 21'(s3_p_ny_ff[11:2])
                          - 21'(s3_qp_ny_ff) + 21'(s3_qp_ny_ff[5:2]);
         s4_leap_in_ff <= is_leap(s3_y_in_ff, s3_qy_in_ff);
         s4_leap_ny_ff <= is_leap(s3_y_ny_ff, s3_qy_ny_ff);
         s4_m_ny_ff    <= s3_m_ny_ff;
         s4_d_ny_ff    <= s3_d_ny_ff;

         s5_ctx_ff   <= s4_ctx_ff;
         s5_dn_in_ff <= s5_dn_in;
         s5_dn_ny_ff <= s5_dn_ny;

         walk_ctx_ff[0]  <= s5_ctx_ff;
         walk_off_ff[0]  <= s6_offset;
         walk_mon_ff[0]  <= 4'd1;
         walk_done_ff[0] <= 1'b0;

         // one month length per stage
         for (int j = 0; j < WALK_STEPS; j++) begin
            walk_ctx_ff[j+1] <= walk_ctx_ff[j];
            if (!walk_done_ff[j] && walk_off_ff[j] > walk_len[j]) begin
               walk_off_ff[j+1]  <= walk_off_ff[j] - walk_len[j];
               walk_mon_ff[j+1]  <= walk_mon_ff[j] + 4'd1;
               walk_done_ff[j+1] <= 1'b0;
            end else begin
               walk_off_ff[j+1]  <= walk_off_ff[j];
               walk_mon_ff[j+1]  <= walk_mon_ff[j];
               walk_done_ff[j+1] <= 1'b1;
            end
         end

         rsp_data_ff <= rsp_in;
      end
   end

   // leap fold, day clamp and solar term match
   always_comb begin
      fin_ctx     = walk_ctx_ff[WALK_STEPS];
      fin_leap    = fin_ctx.months[16:13];
      fin_mon     = walk_mon_ff[WALK_STEPS];
      fin_is_leap = 1'b0;
      if (fin_leap != 4'd0 && fin_mon > fin_leap) begin
         fin_mon     = fin_mon - 4'd1;
         fin_is_leap = (fin_mon == fin_leap);
      end
      fin_off = walk_off_ff[WALK_STEPS];
      priority if (fin_off < 22'sd1) begin
         fin_day = 5'd1;
      end else if (fin_off > 22'sd31) begin
         fin_day = 5'd31;
      end else begin
         fin_day = fin_off[4:0];
      end
      fin_term = {fin_ctx.month - 4'd1, 1'b0};
      priority if (fin_ctx.day == fin_ctx.term_even) begin
         fin_sterm = fin_term;
      end else if (fin_ctx.day == fin_ctx.term_odd) begin
         fin_sterm = fin_term + 5'd1;
      end else begin
         fin_sterm = NO_TERM;
      end
      if (fin_ctx.ok) begin
         rsp_in.ok         = 1'b1;
         rsp_in.lunar_year = fin_ctx.lyear;
         rsp_in.moon_month = fin_mon;
         rsp_in.lunar_day  = fin_day;
         rsp_in.leap_flag  = fin_is_leap;
         rsp_in.term_no    = fin_sterm;
      end else begin
         rsp_in.ok         = 1'b0;
         rsp_in.lunar_year = 12'd0;
         rsp_in.moon_month = 4'd0;
         rsp_in.lunar_day  = 5'd0;
         rsp_in.leap_flag  = 1'b0;
         rsp_in.term_no    = NO_TERM;
      end
   end

   // valid bits travel with the items; only converts make results
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= WALK_STEPS; j++) begin
            walk_v_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff      <= req_valid && (req_data.op == OP_CONVERT);
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         walk_v_ff[0] <= s5_v_ff;
         for (int j = 0; j < WALK_STEPS; j++) begin
            walk_v_ff[j+1] <= walk_v_ff[j];
         end
         rsp_valid_ff <= walk_v_ff[WALK_STEPS];
      end
   end

`ifndef SYNTH
   // a rejected date carries all-zero fields and no solar term
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |-> rsp_data_ff.lunar_year == 12'd0
         && rsp_data_ff.moon_month == 4'd0 && rsp_data_ff.lunar_day == 5'd0
         && !rsp_data_ff.leap_flag && rsp_data_ff.term_no == NO_TERM)
      else $error("rejected item has nonzero fields");

   // a converted date has month and day from one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.ok |-> rsp_data_ff.moon_month != 4'd0
         && rsp_data_ff.lunar_day != 5'd0 && rsp_data_ff.term_no <= NO_TERM)
      else $error("converted item out of range");

   // the month walk never goes past fourteen
   assert property (@(posedge clock) disable iff (reset)
      walk_v_ff[WALK_STEPS] |-> walk_mon_ff[WALK_STEPS] <= 4'd14)
      else $error("month walk overran");
`endif

endmodule

### tb/sv/tb.sv
// testbench for the gregorian to lunar date unit: table loads, directed and random converts
`timescale 1ns / 1ps

module tb;
   import gld_pkg::*;

   localparam int FIRST_YR  = 1901;
   localparam int NUM_YEARS = 256;
   localparam int RANDOM_ITEMS = 800;
   localparam int PHASE_LEN    = 300;
   // year slots that get loaded: the low block and the top few
   localparam int LOW_SLOTS  = 32;
   localparam int HIGH_SLOTS = 4;

   // cumulative days before each month, zero for bad months
   localparam int MONTH_START [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                       334, 0, 0, 0};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predictor copy of the year tables
   logic [20:0] new_year_rows [NUM_YEARS];
   logic [16:0] month_len_rows [NUM_YEARS];
   logic [4:0]  term_day_rows [NUM_YEARS * TERMS_PER_YEAR];

   req_type pending_items [$];
   rsp_type lunar_expected [$];
   int      offered = 0;
   int      fail_count = 0;
   int      hold_cycles = 0;
   bit      hold_done = 0;

   gregorian_to_lunar_date_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   function automatic bit greg_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // day count from a fixed epoch
   function automatic int unsigned epoch_days(int unsigned y, int unsigned m, int unsigned d);
      int unsigned p;
      int unsigned n;
      p = (y > 0) ? y - 1 : 0;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      n += MONTH_START[m & 15] + d;
      if (m > 2 && m <= 12 && greg_leap(y)) n++;
      return n;
   endfunction

   // lunar date for one convert item
   function automatic rsp_type lunar_date_of(req_type it);
      rsp_type     r;
      int unsigned row;
      int unsigned slot;
      logic [20:0] date_key;
      logic [20:0] ny;
      logic [16:0] lens;
      int          offset;
      int          len;
      int unsigned lmonth;
      int unsigned leap_no;
      int unsigned term;
      r = '0;
      r.term_no = NO_TERM;
      if (it.year < FIRST_YR || it.year > FIRST_YR + NUM_YEARS - 1 || it.month < 1 ||
          it.month > 12 || it.day == 0) return r;
      row = it.year - FIRST_YR;
      slot = row;
      date_key = {it.year, it.month, it.day};
      if (new_year_rows[slot] > date_key) begin
         if (slot == 0) return r;
         slot--;
      end
      ny = new_year_rows[slot];
      offset = int'(epoch_days(it.year, it.month, it.day))
             - int'(epoch_days(ny[20:9], ny[8:5], ny[4:0])) + 1;
      lens = month_len_rows[slot];
      lmonth = 1;
      for (int i = 0; i < 13; i++) begin
         len = lens[12 - i] ? 30 : 29;
         if (offset <= len) break;
         offset -= len;
         lmonth++;
      end
      leap_no = lens[16:13];
      if (leap_no != 0 && lmonth > leap_no) begin
         lmonth--;
         r.leap_flag = (lmonth == leap_no);
      end
      if (offset < 1) offset = 1;
      if (offset > 31) offset = 31;
      term = (it.month - 1) * 2;
      if (it.day == term_day_rows[row * TERMS_PER_YEAR + term]) r.term_no = 5'(term);
      else if (it.day == term_day_rows[row * TERMS_PER_YEAR + term + 1])
         r.term_no = 5'(term + 1);
      r.ok = 1'b1;
      r.lunar_year = 12'(FIRST_YR + slot);
      r.moon_month = 4'(lmonth);
      r.lunar_day = 5'(offset);
      return r;
   endfunction

   // update tables or queue the expected date for an accepted item
   task automatic track_item(req_type it);
      case (op_type'(it.op))
         OP_WR_NEW_YEAR: new_year_rows[it.table_index] = it.table_value;
         OP_WR_MONTHS:   month_len_rows[it.table_index] = it.table_value[16:0];
         OP_WR_TERM: begin
            if (it.term_index < TERMS_PER_YEAR)
               term_day_rows[it.table_index * TERMS_PER_YEAR + it.term_index] =
                  it.table_value[4:0];
         end
         default:        lunar_expected.push_back(lunar_date_of(it));
      endcase
   endtask

   function automatic req_type mk(op_type op, int y, int m, int d, int ti, int tr, int v);
      req_type it;
      it.op = op;
      it.year = 12'(y);
      it.month = 4'(m);
      it.day = 5'(d);
      it.table_index = 8'(ti);
      it.term_index = 5'(tr);
      it.table_value = 21'(v);
      return it;
   endfunction

   // plausible new-year date for a slot: late january to mid february
   function automatic int plausible_new_year(int s);
      int m;
      m = $urandom_range(1, 2);
      return ((FIRST_YR + s) << 9) | (m << 5) | ((m == 1) ? $urandom_range(21, 31)
                                                           : $urandom_range(1, 20));
   endfunction

   // year whose slot is loaded, and the slot before it where there is one
   function automatic int pick_year();
      if ($urandom_range(7) == 0)
         return $urandom_range(FIRST_YR + NUM_YEARS - HIGH_SLOTS + 1, FIRST_YR + NUM_YEARS - 1);
      return $urandom_range(FIRST_YR, FIRST_YR + LOW_SLOTS - 1);
   endfunction

   // sender side: present items, track accepted ones
   always @(posedge clock) begin
      int pct;
      pct = (((offered / PHASE_LEN) % 4) == 1) ? 45 : (((offered / PHASE_LEN) % 4) == 3) ? 16 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_item(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= pct) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
               offered++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver side: random stalls plus one long hold-off
   always @(posedge clock) begin
      int pct;
      pct = (((offered / PHASE_LEN) % 4) == 2) ? 45 : (((offered / PHASE_LEN) % 4) == 3) ? 16 : 0;
      if (!hold_done && offered >= 1000) begin
         hold_done <= 1;
         hold_cycles <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < pct);
      end
   end

   // result check against the oldest expected date
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lunar_expected.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            fail_count++;
         end else begin
            exp_r = lunar_expected.pop_front();
            if (exp_r.ok !== rsp_data.ok || exp_r.lunar_year !== rsp_data.lunar_year ||
                exp_r.moon_month !== rsp_data.moon_month ||
                exp_r.lunar_day !== rsp_data.lunar_day ||
                exp_r.leap_flag !== rsp_data.leap_flag ||
                exp_r.term_no !== rsp_data.term_no) begin
               $display("%0t: mismatch expected %p actual %p", $time, exp_r, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int y;
      int m;
      int k;
      // load the low and top year slots; in-range converts stay inside them
      for (int s = 0; s < NUM_YEARS; s++) begin
         if (s < LOW_SLOTS || s >= NUM_YEARS - HIGH_SLOTS) begin
            pending_items.push_back(mk(OP_WR_NEW_YEAR, $urandom, $urandom, $urandom, s,
               $urandom,
               (s == 0) ? ((FIRST_YR << 9) | (2 << 5) | 19) : plausible_new_year(s)));
            pending_items.push_back(mk(OP_WR_MONTHS, $urandom, $urandom, $urandom, s, $urandom,
               ($urandom_range(1) ? $urandom_range(1, 12) << 13 : 0) | $urandom_range(8191)));
            for (int t = 0; t < TERMS_PER_YEAR; t++)
               pending_items.push_back(mk(OP_WR_TERM, 0, 0, 0, s, t,
                  (t % 2 == 0) ? $urandom_range(3, 8) : $urandom_range(18, 23)));
         end
      end
      // directed: range edges, bad months and days, before first new year, leap, terms
      pending_items.push_back(mk(OP_CONVERT, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 4095, 15, 31, 255, 31, 21'h1fffff));
      pending_items.push_back(mk(OP_CONVERT, 1900, 12, 31, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 2157, 1, 1, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1901, 1, 1, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1901, 2, 19, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 2156, 12, 31, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1921, 0, 10, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1921, 13, 10, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1921, 5, 0, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1922, 2, 31, 0, 0, 0));
      pending_items.push_back(mk(OP_WR_TERM, 0, 0, 0, 20, 8, 7));
      pending_items.push_back(mk(OP_WR_TERM, 0, 0, 0, 20, 9, 21));
      pending_items.push_back(mk(OP_WR_TERM, 0, 0, 0, 20, 24, 7));
      pending_items.push_back(mk(OP_WR_TERM, 0, 0, 0, 20, 31, 21'h1fffff));
      pending_items.push_back(mk(OP_CONVERT, 1921, 5, 7, 0, 0, 0));
      pending_items.push_back(mk(OP_CONVERT, 1921, 5, 21, 0, 0, 0));
      // leap month 4 with all long months, then a far date that runs past 13 steps
      pending_items.push_back(mk(OP_WR_MONTHS, 0, 0, 0, 10, 0, (4 << 13) | 8191));
      pending_items.push_back(mk(OP_CONVERT, 1911, 11, 30, 0, 0, 0));
      pending_items.push_back(mk(OP_WR_NEW_YEAR, 0, 0, 0, 15, 0, (1916 << 9) | (1 << 5) | 1));
      pending_items.push_back(mk(OP_WR_MONTHS, 0, 0, 0, 15, 0, 0));
      pending_items.push_back(mk(OP_WR_NEW_YEAR, 0, 0, 0, 16, 0, (1917 << 9) | (2 << 5) | 10));
      pending_items.push_back(mk(OP_CONVERT, 1917, 1, 31, 0, 0, 0));
      // bad new-year entries: month out of range, year zero
      pending_items.push_back(mk(OP_WR_NEW_YEAR, 0, 0, 0, 25, 0, (1926 << 9) | (14 << 5) | 3));
      pending_items.push_back(mk(OP_CONVERT, 1926, 6, 15, 0, 0, 0));
      pending_items.push_back(mk(OP_WR_NEW_YEAR, 0, 0, 0, 26, 0, 21'h1ff));
      pending_items.push_back(mk(OP_CONVERT, 1927, 3, 3, 0, 0, 0));
      // random part: mostly in-range converts, some rewrites, some noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         k = $urandom_range(99);
         y = pick_year();
         m = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
         if (k < 70)
            pending_items.push_back(mk(OP_CONVERT, y, m, $urandom_range(1, 31), $urandom,
               $urandom, $urandom));
         else if (k < 80)
            pending_items.push_back(mk(OP_CONVERT,
               $urandom_range(1) ? y : $urandom_range(0, FIRST_YR - 1), $urandom, $urandom,
               $urandom, $urandom, $urandom));
         else if (k < 86)
            pending_items.push_back(mk(OP_WR_NEW_YEAR, $urandom, $urandom, $urandom, $urandom,
               $urandom, ($urandom_range(3) == 0) ? $urandom : plausible_new_year(y - FIRST_YR)));
         else if (k < 92)
            pending_items.push_back(mk(OP_WR_MONTHS, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom));
         else
            pending_items.push_back(mk(OP_WR_TERM, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(31), $urandom));
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || req_valid || lunar_expected.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("gregorian_to_lunar_date_unit regression: pass");
      else $display("gregorian_to_lunar_date_unit regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("gregorian_to_lunar_date_unit regression: fail");
      $finish;
   end

endmodule
